// ===== sv/i2cms_pkg.sv =====
`timescale 1ns / 1ps

package i2cms_pkg;

  // Default depth of the write byte store.
  localparam int DEF_WRITE_DEPTH = 16;

  // Read counts above this limit are treated as the limit.
  localparam int READ_MAX = 255;

  // Input opcodes.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_EVENT = 2'd2;

  // Transfer status codes.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [1:0] ST_ERR  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SLAVE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_WRITE_COUNT   = 2'd1;
  localparam logic [1:0] CFG_READ_COUNT    = 2'd2;

  // One input item.
  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] load_index;
    logic [7:0] load_byte;
    logic       slave_acked;
    logic [7:0] received_byte;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic       start_cmd;
    logic       stop_cmd;
    logic       restart_cmd;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       receive_dir;
    logic       nack_next;
    logic       dummy_read;
    logic       rd_valid;
    logic [7:0] rd_index;
    logic [7:0] rd_byte;
    logic [1:0] status;
  } out_item_t;

  // Configuration write as seen by the sequencer.
  typedef struct packed {
    logic       en;
    logic [1:0] index;
    logic [7:0] data;
  } cfg_wr_t;

endpackage

// ===== sv/i2cms_seq.sv =====
`timescale 1ns / 1ps

module i2cms_seq
  import i2cms_pkg::*;
#(
  parameter int WRITE_DEPTH = DEF_WRITE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  in_item_t  item,
  input  cfg_wr_t   cfg,
  output out_item_t result
);

  localparam int AW = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
  localparam int PW = $clog2(WRITE_DEPTH + 1);

  // Configuration registers.
  logic [6:0] slave_address_r;
  logic [4:0] write_count_r;
  logic [7:0] read_count_r;

  // Transfer state.
  logic [PW-1:0] write_pos_r, write_pos_nxt;
  logic [7:0]    read_pos_r, read_pos_nxt;
  logic          in_read_phase_r, in_read_phase_nxt;
  logic          receiving_r, receiving_nxt;
  logic [1:0]    status_r, status_nxt;

  // Write byte store and its registered read port.
  logic [7:0]    store_mem [WRITE_DEPTH];
  logic [7:0]    store_q_r;
  logic          load_hit;
  logic [AW-1:0] load_addr;
  logic [AW-1:0] rd_addr;

  logic [PW-1:0] eff_wc;
  logic [7:0]    eff_rc;
  logic [7:0]    addr_byte;
  logic [8:0]    read_pos_p1;
  logic [8:0]    read_pos_p2;

  // Counts clamped to what the design supports.
  assign eff_wc = (32'(write_count_r) > WRITE_DEPTH) ? PW'(WRITE_DEPTH) : PW'(write_count_r);
  assign eff_rc = (32'(read_count_r) > READ_MAX) ? 8'(READ_MAX) : read_count_r;

  assign addr_byte   = {slave_address_r, 1'b0};
  assign read_pos_p1 = {1'b0, read_pos_r} + 9'd1;
  assign read_pos_p2 = {1'b0, read_pos_r} + 9'd2;

  assign load_hit  = accept && (item.opcode == OP_LOAD) && (32'(item.load_index) < WRITE_DEPTH);
  assign load_addr = AW'(item.load_index);
  assign rd_addr   = (32'(write_pos_nxt) < WRITE_DEPTH) ? AW'(write_pos_nxt) : '0;

  // Next state and result for the item at the input.
  always_comb begin
    write_pos_nxt     = write_pos_r;
    read_pos_nxt      = read_pos_r;
    in_read_phase_nxt = in_read_phase_r;
    receiving_nxt     = receiving_r;
    status_nxt        = status_r;
    result            = '0;

    if (accept) begin
      case (item.opcode)
        OP_START: begin
          if (status_r != ST_BUSY) begin
            write_pos_nxt     = '0;
            read_pos_nxt      = '0;
            in_read_phase_nxt = 1'b0;
            receiving_nxt     = 1'b0;
            status_nxt        = ST_BUSY;
            result.start_cmd  = 1'b1;
            result.tx_valid   = 1'b1;
            result.tx_byte    = addr_byte;
          end
        end
        OP_EVENT: begin
          if (status_r == ST_BUSY) begin
            if (!receiving_r) begin
              if (write_pos_r >= eff_wc) begin
                // Write phase over: read setup, or finish.
                if (eff_rc != 8'd0) begin
                  if (!item.slave_acked) begin
                    status_nxt      = ST_ERR;
                    result.stop_cmd = 1'b1;
                  end else if (in_read_phase_r) begin
                    receiving_nxt     = 1'b1;
                    result.nack_next  = (eff_rc == 8'd1);
                    result.dummy_read = 1'b1;
                  end else begin
                    result.restart_cmd = 1'b1;
                    result.tx_valid    = 1'b1;
                    result.tx_byte     = addr_byte | 8'd1;
                    in_read_phase_nxt  = 1'b1;
                  end
                end else begin
                  status_nxt      = ST_DONE;
                  result.stop_cmd = 1'b1;
                end
              end else if (!item.slave_acked) begin
                status_nxt      = ST_ERR;
                result.stop_cmd = 1'b1;
              end else begin
                result.tx_valid = 1'b1;
                result.tx_byte  = store_q_r;
                write_pos_nxt   = write_pos_r + PW'(1);
              end
            end else if ((eff_rc != 8'd0) && (read_pos_r < eff_rc)) begin
              // Deliver a received byte.
              result.rd_valid = 1'b1;
              result.rd_index = read_pos_r;
              result.rd_byte  = item.received_byte;
              if (read_pos_p1 == {1'b0, eff_rc}) begin
                receiving_nxt   = 1'b0;
                result.stop_cmd = 1'b1;
                status_nxt      = ST_DONE;
              end else if (read_pos_p2 == {1'b0, eff_rc}) begin
                result.nack_next = 1'b1;
              end
              read_pos_nxt = read_pos_r + 8'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    result.receive_dir = receiving_nxt;
    result.status      = status_nxt;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_pos_r     <= '0;
      read_pos_r      <= '0;
      in_read_phase_r <= 1'b0;
      receiving_r     <= 1'b0;
      status_r        <= ST_IDLE;
    end else begin
      write_pos_r     <= write_pos_nxt;
      read_pos_r      <= read_pos_nxt;
      in_read_phase_r <= in_read_phase_nxt;
      receiving_r     <= receiving_nxt;
      status_r        <= status_nxt;
    end
  end

  // Configuration writes are dropped while a transfer runs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_address_r <= '0;
      write_count_r   <= '0;
      read_count_r    <= '0;
    end else if (cfg.en && (status_r != ST_BUSY)) begin
      case (cfg.index)
        CFG_SLAVE_ADDRESS: slave_address_r <= cfg.data[6:0];
        CFG_WRITE_COUNT:   write_count_r   <= cfg.data[4:0];
        CFG_READ_COUNT:    read_count_r    <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // Store write, and a read of the entry the next event will send.
  // A load to that same entry is forwarded.
  always_ff @(posedge clk) begin
    if (load_hit) begin
      store_mem[load_addr] <= item.load_byte;
    end
    if (load_hit && (load_addr == rd_addr)) begin
      store_q_r <= item.load_byte;
    end else begin
      store_q_r <= store_mem[rd_addr];
    end
  end

  // Receiving only happens inside the read phase of a running transfer.
  a_recv_in_read_phase: assert property (@(posedge clk) disable iff (!rst_n)
    receiving_r |-> (in_read_phase_r && (status_r == ST_BUSY)))
    else $error("receiving outside the read phase");

  // The read position never passes the read count while receiving.
  a_read_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    receiving_r |-> (read_pos_r < eff_rc))
    else $error("read position beyond read count");

  // The write position never passes the write count during a transfer.
  a_write_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r == ST_BUSY) |-> (write_pos_r <= eff_wc))
    else $error("write position beyond write count");

  // A delivered byte ends the transfer exactly when it is the last one.
  a_last_byte_done: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && result.rd_valid && (read_pos_p1 == {1'b0, eff_rc}))
      |=> ((status_r == ST_DONE) && !receiving_r))
    else $error("last received byte did not finish the transfer");

endmodule

// ===== sv/i2cms_skid.sv =====
`timescale 1ns / 1ps

module i2cms_skid
  import i2cms_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  out_item_t in_data,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      out_valid_r;
  out_item_t out_data_r;
  logic      skid_valid_r;
  out_item_t skid_data_r;
  logic      take;
  logic      drain;

  // Upstream is held off only once the spare stage is occupied.
  assign in_stall  = skid_valid_r;
  assign take      = in_valid && !skid_valid_r;
  assign drain     = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (drain) begin
        skid_valid_r <= 1'b0;
      end
    end else if (out_valid_r && !drain) begin
      skid_valid_r <= take;
    end else begin
      out_valid_r <= take;
    end
  end

  // Payload: the output register is loaded when it is free or drains.
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (drain) begin
        out_data_r <= skid_data_r;
      end
    end else if (out_valid_r && !drain) begin
      if (take) begin
        skid_data_r <= in_data;
      end
    end else if (take) begin
      out_data_r <= in_data;
    end
  end

  // The spare stage is only used behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("spare stage full with output register empty");

  // An item taken while the output is stalled lands in the spare stage.
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (take && out_valid_r && out_stall) |=> skid_valid_r)
    else $error("item lost behind a stalled output");

  // A drained output is refilled from the spare stage in order.
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_stall) |=> (out_valid_r && (out_data_r == $past(skid_data_r))))
    else $error("spare stage item not forwarded");

endmodule

// ===== sv/i2c_master_transfer_sequencer_core.sv =====
`timescale 1ns / 1ps

// I2C master write-then-read sequencer on top of a byte-level controller.
// Input channel (in_valid / in_stall / in_data): load a write byte, start a
// transaction, or report a byte transfer complete with the slave's ACK and
// the received data. Every accepted item yields exactly one result item on
// the output channel (out_valid / out_stall / out_data) carrying the
// controller commands: START, repeated START, STOP, byte to send, receive
// direction, NACK, dummy read, delivered read byte and transfer status.
// Configuration (cfg_wr_en / cfg_index / cfg_wdata) sets address, write
// count and read count; writes are dropped while a transfer is busy.
// A result is registered in the output stage once its item is accepted.
// Throughput is one item per cycle while in_stall is low, set by the single
// register stage that holds the transfer state and the registered store read.
// When the receiver stalls, one more item is absorbed into a spare stage,
// and in_stall then rises until the output drains.
// Synchronous reset clears status to idle, all positions and counts, and
// empties the output stages; the write store holds no reset value.
module i2c_master_transfer_sequencer_core
  import i2cms_pkg::*;
#(
  parameter int WRITE_DEPTH = DEF_WRITE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  logic      accept;
  out_item_t result;
  cfg_wr_t   cfg;

  assign accept    = in_valid && !in_stall;
  assign cfg.en    = cfg_wr_en;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_wdata;

  // Transfer state and command generation.
  i2cms_seq #(
    .WRITE_DEPTH(WRITE_DEPTH)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .accept(accept),
    .item  (in_data),
    .cfg   (cfg),
    .result(result)
  );

  // Result register with a spare stage for receiver stalls.
  i2cms_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (result),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
